/* rtl/nearest_scaler_pixel_repack_top_macros.svh */
// Assertion macros shared by the scaler RTL.
// NO_ASSERTIONS removes every check.
`ifndef NEAREST_SCALER_PIXEL_REPACK_TOP_MACROS_SVH
`define NEAREST_SCALER_PIXEL_REPACK_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define NSPR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nspr: assertion failed");
// Next-cycle implication.
`define NSPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nspr: assertion failed");
`else
`define NSPR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define NSPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/nspr_pkg.sv */
package nspr_pkg;

   localparam int STORE_PIXELS = 65536;
   localparam int MAX_DIM      = 4096;

   localparam int STORE_AW  = $clog2(STORE_PIXELS);
   localparam int LOAD_W    = $clog2(STORE_PIXELS + 1);
   localparam int POS_W     = $clog2(MAX_DIM);
   localparam int SRC_W     = 11;
   localparam int DIM_W     = 13;
   localparam int SHIFT_W   = 5;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int WORD_W    = 32;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = POS_W + SRC_W;
   localparam int ADDR_W    = 2 * SRC_W;
   localparam int CNT_W     = $clog2(PROD_W + 1);

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_OUTPUT = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH   = 3'd0,
      CSR_SRC_HEIGHT  = 3'd1,
      CSR_DST_WIDTH   = 3'd2,
      CSR_DST_HEIGHT  = 3'd3,
      CSR_RED_SHIFT   = 3'd4,
      CSR_GREEN_SHIFT = 3'd5,
      CSR_BLUE_SHIFT  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic              kind;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              frame_start;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] pixel;
      logic              line_end;
      logic              frame_end;
   } rsp_type;

endpackage

/* rtl/nspr_ram.sv */
module nspr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/nspr_scale.sv */
// floor(pos * src / dst), clamped to src - 1.
// Product taken at go, then one restoring quotient bit per cycle.
module nspr_scale (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic [nspr_pkg::POS_W-1:0] pos,
   input  logic [nspr_pkg::SRC_W-1:0] src,
   input  logic [nspr_pkg::DIM_W-1:0] dst,
   output logic                      done,
   output logic [nspr_pkg::SRC_W-1:0] index
);
   import nspr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_CLAMP
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DIM_W-1:0]   rem_ff;
   logic [PROD_W-1:0]  quo_ff;
   logic [SRC_W-1:0]   src_ff;
   logic [DIM_W-1:0]   dst_ff;
   logic               done_ff;
   logic [SRC_W-1:0]   index_ff;

   logic [PROD_W-1:0]  prod;
   logic [DIM_W:0]     trial;
   logic               take;
   logic [DIM_W-1:0]   rem_in;
   logic [SRC_W-1:0]   index_in;

   assign prod  = PROD_W'(pos) * PROD_W'(src);
   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign take  = trial >= {1'b0, dst_ff};
   // remainder stays below dst, so it fits DIM_W bits
   assign rem_in = take ? DIM_W'(trial - {1'b0, dst_ff}) : trial[DIM_W-1:0];
   assign index_in = (quo_ff >= PROD_W'(src_ff)) ? src_ff - SRC_W'(1)
                                                 : quo_ff[SRC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (go) begin
                  quo_ff   <= prod;
                  rem_ff   <= '0;
                  cnt_ff   <= CNT_W'(PROD_W);
                  src_ff   <= src;
                  dst_ff   <= dst;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= {quo_ff[PROD_W-2:0], take};
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= S_CLAMP;
               end
            end
            S_CLAMP: begin
               index_ff <= index_in;
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign index = index_ff;

endmodule

/* rtl/nearest_scaler_pixel_repack_top.sv */
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+--------------------------------------
// request  | start, busy, req_data          | taken when start && !busy
// response | rsp_valid, rsp_data            | one-cycle strobe, cannot be held off
// csr      | csr_we, csr_index, csr_wdata   | written on any edge with csr_we high
//
// A load item writes the frame store in the accept cycle, unless the store is full.
// An output request runs the 23-step quotient loop in nspr_scale (one bit per
// cycle), then address multiply, one frame-store read and repack; busy is high
// throughout, so no new request is taken before the last one is done.
// Synchronous active-high reset clears the rasters and returns the registers
// to their defaults; the frame store is not cleared.
// The response strobe is registered; the receiver has no stall.

`include "nearest_scaler_pixel_repack_top_macros.svh"

module nearest_scaler_pixel_repack_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  nspr_pkg::req_type             req_data,
   output logic                          rsp_valid,
   output nspr_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [nspr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nspr_pkg::CSR_W-1:0]    csr_wdata
);
   import nspr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_READ,
      ST_FORM
   } state_type;

   // zero acts as one
   function automatic logic [SRC_W-1:0] src_dim(input logic [SRC_W-1:0] v);
      return (v == '0) ? SRC_W'(1) : v;
   endfunction

   // zero acts as one, oversized clamps to the largest raster
   function automatic logic [DIM_W-1:0] dst_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

   // configuration
   logic [SRC_W-1:0]   src_width_ff, src_height_ff;
   logic [DIM_W-1:0]   dst_width_ff, dst_height_ff;
   logic [SHIFT_W-1:0] red_shift_ff, green_shift_ff, blue_shift_ff;

   // control
   state_type          state_ff;
   logic [LOAD_W-1:0]  load_addr_ff;
   logic [POS_W-1:0]   out_col_ff, out_row_ff;
   logic               lend_ff, fend_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic               in_range_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // datapath
   logic               accept, is_load, is_out, restart;
   logic [SRC_W-1:0]   sw_eff, sh_eff;
   logic [DIM_W-1:0]   dw_eff, dh_eff;
   logic [POS_W-1:0]   col_use, row_use;
   logic               lend, fend;
   logic [LOAD_W-1:0]  load_use;
   logic               store_full;
   logic               ram_we, ram_re;
   logic [PIX_W-1:0]   ram_rdata;
   logic               col_done, row_done;
   logic [SRC_W-1:0]   col_idx, row_idx;
   logic [WORD_W-1:0]  word;

   assign accept  = start && !busy;
   assign is_load = accept && (req_data.kind == KIND_LOAD);
   assign is_out  = accept && (req_data.kind == KIND_OUTPUT);
   assign restart = req_data.frame_start;

   assign sw_eff = src_dim(src_width_ff);
   assign sh_eff = src_dim(src_height_ff);
   assign dw_eff = dst_dim(dst_width_ff);
   assign dh_eff = dst_dim(dst_height_ff);

   // raster position; a position past the edge counts as the last one
   assign col_use = restart ? '0 : out_col_ff;
   assign row_use = restart ? '0 : out_row_ff;
   assign lend    = DIM_W'(col_use) >= dw_eff - DIM_W'(1);
   assign fend    = lend && (DIM_W'(row_use) >= dh_eff - DIM_W'(1));

   // loads past capacity are dropped
   assign load_use   = (restart && (req_data.kind == KIND_LOAD)) ? '0 : load_addr_ff;
   assign store_full = 32'(load_use) >= 32'(STORE_PIXELS);
   assign ram_we     = is_load && !store_full;
   assign ram_re     = state_ff == ST_READ;

   nspr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_PIXELS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (load_use[STORE_AW-1:0]),
      .wdata ({req_data.red, req_data.green, req_data.blue}),
      .re    (ram_re),
      .raddr (addr_ff[STORE_AW-1:0]),
      .rdata (ram_rdata)
   );

   nspr_scale u_scale_col (
      .clock (clock),
      .reset (reset),
      .go    (is_out),
      .pos   (col_use),
      .src   (sw_eff),
      .dst   (dw_eff),
      .done  (col_done),
      .index (col_idx)
   );

   nspr_scale u_scale_row (
      .clock (clock),
      .reset (reset),
      .go    (is_out),
      .pos   (row_use),
      .src   (sh_eff),
      .dst   (dh_eff),
      .done  (row_done),
      .index (row_idx)
   );

   // repack; bits pushed past the top are lost, overlaps OR together
   assign word = (WORD_W'(ram_rdata[3*CHAN_W-1:2*CHAN_W]) << red_shift_ff)
               | (WORD_W'(ram_rdata[2*CHAN_W-1:CHAN_W])   << green_shift_ff)
               | (WORD_W'(ram_rdata[CHAN_W-1:0])          << blue_shift_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= SRC_W'(256);
         src_height_ff  <= SRC_W'(256);
         dst_width_ff   <= DIM_W'(256);
         dst_height_ff  <= DIM_W'(256);
         red_shift_ff   <= SHIFT_W'(16);
         green_shift_ff <= SHIFT_W'(8);
         blue_shift_ff  <= SHIFT_W'(0);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:   src_width_ff   <= csr_wdata[SRC_W-1:0];
            CSR_SRC_HEIGHT:  src_height_ff  <= csr_wdata[SRC_W-1:0];
            CSR_DST_WIDTH:   dst_width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_DST_HEIGHT:  dst_height_ff  <= csr_wdata[DIM_W-1:0];
            CSR_RED_SHIFT:   red_shift_ff   <= csr_wdata[SHIFT_W-1:0];
            CSR_GREEN_SHIFT: green_shift_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_BLUE_SHIFT:  blue_shift_ff  <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_addr_ff <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (is_load) begin
                  load_addr_ff <= store_full ? load_use : load_use + LOAD_W'(1);
               end
               if (is_out) begin
                  // raster advances now; flags travel with the item
                  lend_ff    <= lend;
                  fend_ff    <= fend;
                  out_col_ff <= lend ? '0 : col_use + POS_W'(1);
                  out_row_ff <= fend ? '0 : (lend ? row_use + POS_W'(1) : row_use);
                  state_ff   <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (col_done) begin
                  addr_ff  <= ADDR_W'(row_idx) * ADDR_W'(sw_eff) + ADDR_W'(col_idx);
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               in_range_ff <= 32'(addr_ff) < 32'(STORE_PIXELS);
               state_ff    <= ST_FORM;
            end
            ST_FORM: begin
               rsp_data_ff.pixel     <= in_range_ff ? word : '0;
               rsp_data_ff.line_end  <= lend_ff;
               rsp_data_ff.frame_end <= fend_ff;
               rsp_valid_ff          <= 1'b1;
               state_ff              <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NSPR_ASSERT_NEXT(a_form_gives_rsp, clock, reset, state_ff == ST_FORM, rsp_valid_ff)
   `NSPR_ASSERT_IMPL(a_rsp_from_form, clock, reset, rsp_valid_ff, $past(state_ff) == ST_FORM)
   `NSPR_ASSERT_IMPL(a_units_in_step, clock, reset, 1'b1, col_done == row_done)
   `NSPR_ASSERT_IMPL(a_load_bound, clock, reset, 1'b1, 32'(load_addr_ff) <= 32'(STORE_PIXELS))
   `NSPR_ASSERT_IMPL(a_frame_in_line, clock, reset, rsp_valid_ff, !rsp_data_ff.frame_end || rsp_data_ff.line_end)

endmodule

/* sim/nearest_scaler_pixel_repack_top_tb.sv */
module nearest_scaler_pixel_repack_top_tb;
   import nspr_pkg::*;

   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int REPORT_LIMIT  = 10;
   // Index 7 has no register behind it. Writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   // Scoreboard: keeps its own copy of the frame store, the two rasters and
   // the registers. It works out each destination pixel when its request is
   // accepted and queues it until the block answers.
   class pixel_scoreboard;
      logic [PIX_W-1:0] frame_mem [STORE_PIXELS];
      bit               loaded    [STORE_PIXELS];
      int unsigned      load_ptr, col_pos, row_pos;
      int unsigned      src_w, src_h, dst_w, dst_h, red_sh, green_sh, blue_sh;
      rsp_type          pixels_due [$];
      int unsigned      errors;

      function new();
         src_w    = 256;
         src_h    = 256;
         dst_w    = 256;
         dst_h    = 256;
         red_sh   = 16;
         green_sh = 8;
         blue_sh  = 0;
      endfunction

      function void note_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_SRC_WIDTH:   src_w    = val[SRC_W-1:0];
            CSR_SRC_HEIGHT:  src_h    = val[SRC_W-1:0];
            CSR_DST_WIDTH:   dst_w    = val[DIM_W-1:0];
            CSR_DST_HEIGHT:  dst_h    = val[DIM_W-1:0];
            CSR_RED_SHIFT:   red_sh   = val[SHIFT_W-1:0];
            CSR_GREEN_SHIFT: green_sh = val[SHIFT_W-1:0];
            CSR_BLUE_SHIFT:  blue_sh  = val[SHIFT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned src_dim(int unsigned v);
         return (v == 0) ? 1 : v;
      endfunction

      function int unsigned dst_dim(int unsigned v);
         if (v == 0)
            return 1;
         return (v > MAX_DIM) ? MAX_DIM : v;
      endfunction

      // floor(pos*s/d), clamped to the last source column or row
      function int unsigned scale_pos(int unsigned pos, int unsigned s, int unsigned d);
         longint unsigned q;
         q = (64'(pos) * 64'(s)) / 64'(d);
         return (q > s - 1) ? s - 1 : q[31:0];
      endfunction

      function longint unsigned source_addr(int unsigned col, int unsigned row);
         int unsigned sw, sh;
         sw = src_dim(src_w);
         sh = src_dim(src_h);
         return 64'(scale_pos(row, sh, dst_dim(dst_h))) * sw
                + scale_pos(col, sw, dst_dim(dst_w));
      endfunction

      function bit reads_unwritten(bit restart);
         longint unsigned a;
         a = restart ? source_addr(0, 0) : source_addr(col_pos, row_pos);
         return a < STORE_PIXELS && !loaded[a];
      endfunction

      function int unsigned pending();
         return pixels_due.size();
      endfunction

      function void take_request(req_type it);
         longint unsigned  a;
         logic [63:0]      word;
         logic [PIX_W-1:0] ent;
         rsp_type          want;
         if (it.kind == KIND_LOAD) begin
            if (it.frame_start)
               load_ptr = 0;
            // store full: the load is dropped and the pointer stays put
            if (load_ptr < STORE_PIXELS) begin
               frame_mem[load_ptr] = {it.red, it.green, it.blue};
               loaded[load_ptr]    = 1'b1;
               load_ptr++;
            end
            return;
         end
         if (it.frame_start) begin
            col_pos = 0;
            row_pos = 0;
         end
         a    = source_addr(col_pos, row_pos);
         word = '0;
         // source address past the store reads as zero
         if (a < STORE_PIXELS) begin
            ent  = frame_mem[a];
            word = (64'(ent[23:16]) << red_sh) | (64'(ent[15:8]) << green_sh)
                   | (64'(ent[7:0]) << blue_sh);
         end
         want.pixel     = word[WORD_W-1:0];
         // a position at or past the edge counts as the last column / row
         want.line_end  = col_pos >= dst_dim(dst_w) - 1;
         want.frame_end = want.line_end && row_pos >= dst_dim(dst_h) - 1;
         if (want.line_end) begin
            col_pos = 0;
            row_pos = want.frame_end ? 0 : row_pos + 1;
         end else begin
            col_pos++;
         end
         pixels_due.push_back(want);
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         if (pixels_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected pixel %h le %b fe %b",
                        got.pixel, got.line_end, got.frame_end);
            return;
         end
         want = pixels_due.pop_front();
         if (got.pixel !== want.pixel || got.line_end !== want.line_end ||
             got.frame_end !== want.frame_end) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("pixel mismatch: expected %h le %b fe %b, got %h le %b fe %b",
                        want.pixel, want.line_end, want.frame_end,
                        got.pixel, got.line_end, got.frame_end);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   pixel_scoreboard sb;
   bit              idle_on;
   int unsigned     cycles = 0;

   nearest_scaler_pixel_repack_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The result strobe cannot be held off: every strobed cycle is one pixel.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_pixel(rsp_data);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic req_type pixel_load(bit fs, logic [PIX_W-1:0] rgb);
      req_type it;
      it.kind                  = KIND_LOAD;
      {it.red, it.green, it.blue} = rgb;
      it.frame_start           = fs;
      return it;
   endfunction

   // Color bytes of a request are ignored by the block, so they get noise.
   function automatic req_type pixel_request(bit fs);
      req_type it;
      it.kind                  = KIND_OUTPUT;
      {it.red, it.green, it.blue} = PIX_W'($urandom);
      it.frame_start           = fs;
      return it;
   endfunction

   // Hand one item to the block. start stays high across back-to-back items;
   // it only drops for an idle gap, a drain pause or a settle.
   task automatic send_item(req_type it);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      // Never read a store entry that has not been loaded since reset:
      // fall back to a raster restart, or failing that, to a load.
      if (it.kind == KIND_OUTPUT && sb.reads_unwritten(it.frame_start)) begin
         if (!sb.reads_unwritten(1'b1)) begin
            it.frame_start = 1'b1;
         end else begin
            it.kind        = KIND_LOAD;
            it.frame_start = 1'b0;
         end
      end
      if (idle_on && $urandom_range(0, 39) == 0) begin
         // drain: hold off until every queued pixel is back
         start <= 1'b0;
         @(posedge clock);
         while (sb.pending() != 0)
            @(posedge clock);
      end else if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sb.take_request(it);
   endtask

   // Stop sending and let the block go quiet. Loads give no result, so a
   // fixed tail covers one that may still be in flight.
   task automatic settle();
      start <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.note_reg(idx, val);
   endtask

   // Full register set, written only once the block is idle.
   task automatic apply_setting(logic [CSR_W-1:0] sw, logic [CSR_W-1:0] sh,
                                logic [CSR_W-1:0] dw, logic [CSR_W-1:0] dh,
                                logic [CSR_W-1:0] rs, logic [CSR_W-1:0] gs,
                                logic [CSR_W-1:0] bs);
      settle();
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_DST_WIDTH, dw);
      write_reg(CSR_DST_HEIGHT, dh);
      write_reg(CSR_RED_SHIFT, rs);
      write_reg(CSR_GREEN_SHIFT, gs);
      write_reg(CSR_BLUE_SHIFT, bs);
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_SPARE, CSR_W'($urandom));
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [CSR_W-1:0] sw, sh, dw, dh, rs, gs, bs;
      int unsigned      pick, roll, n, m, k, random_sent;

      sb = new();
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      idle_on     = 1'b0;
      random_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // Reset setting: 256x256 in and out, packed as 0x00RRGGBB, so pixel i
      // of the first row is store entry i. Color extremes first.
      send_item(pixel_load(1'b1, 24'hFFFFFF));
      send_item(pixel_load(1'b0, 24'h000000));
      send_item(pixel_load(1'b0, 24'hA55AC3));
      send_item(pixel_load(1'b0, 24'h01807F));
      send_item(pixel_request(1'b1));
      repeat (3) send_item(pixel_request(1'b0));

      // 2x2 up to 3x3 with overlapping colors ORed. The raster sits at
      // column 4, past the new width: first pixel must close the line.
      apply_setting(2, 2, 3, 3, 4, 0, 2);
      repeat (7) send_item(pixel_request(1'b0));
      // load restart overwrites entry 0
      send_item(pixel_load(1'b1, 24'h123456));

      // All dimensions zero act as one; big shifts lose their top bits.
      apply_setting(0, 0, 0, 0, 31, 24, 13);
      repeat (2) send_item(pixel_request(1'b0));

      // 1024x1024 source into one column of two rows: row 1 maps to source
      // row 512, far past the store, and reads as zero.
      apply_setting(1024, 1024, 1, 2, 24, 16, 8);
      send_item(pixel_request(1'b1));
      send_item(pixel_request(1'b0));

      // Full-width register values: oversized destination clamps to MAX_DIM.
      apply_setting(2047, 5, 8191, 8191, 16, 8, 0);
      send_item(pixel_request(1'b1));
      send_item(pixel_request(1'b0));

      // ---- random part ----
      // Each phase: new setting, a source frame of at most 200 pixels loaded in
      // raster order, then mostly output requests with a few stray loads and restarts.
      while (random_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            sw = CSR_W'($urandom_range(1, 12));
            sh = CSR_W'($urandom_range(1, 12));
            dw = CSR_W'($urandom_range(1, 16));
            dh = CSR_W'($urandom_range(1, 16));
         end else if (pick == 7) begin
            sw = $urandom_range(0, 1) ? '0 : CSR_W'($urandom_range(1, 6));
            sh = $urandom_range(0, 1) ? '0 : CSR_W'($urandom_range(1, 6));
            dw = $urandom_range(0, 1) ? '0 : CSR_W'($urandom_range(1, 8));
            dh = $urandom_range(0, 1) ? '0 : CSR_W'($urandom_range(1, 8));
         end else if (pick == 8) begin
            sw = 1024;
            sh = 1024;
            dw = 4096;
            dh = 4096;
         end else begin
            sw = CSR_W'($urandom_range(0, 2047));
            sh = CSR_W'($urandom_range(0, 2047));
            dw = CSR_W'($urandom_range(0, 8191));
            dh = CSR_W'($urandom_range(0, 8191));
         end
         rs = ($urandom_range(0, 4) != 0) ? CSR_W'($urandom_range(0, 24)) : CSR_W'($urandom);
         gs = ($urandom_range(0, 4) != 0) ? CSR_W'($urandom_range(0, 24)) : CSR_W'($urandom);
         bs = ($urandom_range(0, 4) != 0) ? CSR_W'($urandom_range(0, 24)) : CSR_W'($urandom);
         apply_setting(sw, sh, dw, dh, rs, gs, bs);
         // one phase in four runs without gaps
         idle_on = $urandom_range(0, 3) != 0;

         n = sb.src_dim(sw[SRC_W-1:0]) * sb.src_dim(sh[SRC_W-1:0]);
         if (n > 200)
            n = $urandom_range(1, 200);
         for (k = 0; k < n; k++)
            send_item(pixel_load(k == 0, PIX_W'($urandom)));

         m = $urandom_range(20, 100);
         for (k = 0; k < m; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
               send_item(pixel_request((k == 0 && $urandom_range(0, 1) == 1) || roll < 3));
            else
               send_item(pixel_load($urandom_range(0, 1), PIX_W'($urandom)));
         end
         random_sent += n + m;
      end

      settle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
